// ===== sv/mffd_pkg.sv =====
// Shared types and constants of the motor feedback frame decoder.
package mffd_pkg;

  localparam int NUM_MOTORS_DEF = 4;
  localparam int FRAC_BITS_DEF  = 16;

  localparam int CFG_ADDR_W = 3;
  localparam logic REG_MODEL_MASK = 1'b0;
  localparam logic REG_EMA_ALPHA  = 1'b1;
  localparam logic [3:0]  MODEL_MASK_RESET = 4'd3;
  localparam logic [16:0] EMA_ALPHA_RESET  = 17'd13107;
  localparam logic [16:0] ALPHA_ONE        = 17'h10000;
  localparam int ALPHA_FRAC = 16;
  localparam int ALPHA_HALF = 32768;

  localparam int QUEUE_DEPTH = 2;

  localparam int WIDE_BITS   = 16;
  localparam int NARROW_BITS = 12;
  localparam logic [15:0] DEN_WIDE   = 16'hFFFF;
  localparam logic [11:0] DEN_NARROW = 12'hFFF;

  // Twice the span of each range, in real units.
  localparam logic [6:0] POS_SPAN2    = 7'd50;
  localparam logic [6:0] VEL_SPAN2_M1 = 7'd40;
  localparam logic [6:0] VEL_SPAN2_M0 = 7'd120;
  localparam logic [6:0] TRQ_SPAN2_M1 = 7'd112;
  localparam logic [6:0] TRQ_SPAN2_M0 = 7'd40;

  typedef struct packed {
    logic [3:0]  slot;
    logic        model;
    logic [3:0]  error_code;
    logic [15:0] pcode;
    logic [11:0] vcode;
    logic [11:0] tcode;
    logic [7:0]  driver_temp;
    logic [7:0]  rotor_temp;
  } item_t;

endpackage

// ===== sv/mffd_front.sv =====
// Front end: takes frames, filters identifiers and unpacks the fields.
module mffd_front #(
  parameter int NUM_MOTORS = mffd_pkg::NUM_MOTORS_DEF
) (
  input  logic              rst,
  input  logic              frame_valid,
  output logic              frame_stall,
  input  logic [10:0]       frame_id,
  input  logic [7:0]        byte0,
  input  logic [7:0]        byte1,
  input  logic [7:0]        byte2,
  input  logic [7:0]        byte3,
  input  logic [7:0]        byte4,
  input  logic [7:0]        byte5,
  input  logic [7:0]        byte6,
  input  logic [7:0]        byte7,
  input  logic [3:0]        model_select_mask,
  input  logic              queue_full,
  output logic              push,
  output mffd_pkg::item_t   item
);
  import mffd_pkg::*;

  logic [10:0] id_m1;
  logic        id_ok;

  always_comb begin
    id_m1 = frame_id - 11'd1;
    id_ok = (frame_id != 11'd0) && (frame_id <= 11'(NUM_MOTORS));
    item.slot        = id_m1[3:0];
    item.model       = (id_m1[3:2] == 2'b00) ? model_select_mask[id_m1[1:0]] : 1'b0;
    item.error_code  = byte0[7:4];
    item.pcode       = {byte1, byte2};
    item.vcode       = {byte3, byte4[7:4]};
    item.tcode       = {byte4[3:0], byte5};
    item.driver_temp = byte6;
    item.rotor_temp  = byte7;
  end

  assign frame_stall = queue_full;
  assign push = frame_valid && !queue_full && id_ok && !rst;

endmodule

// ===== sv/mffd_queue.sv =====
// Short queue of unpacked frames between the front end and the back end.
module mffd_queue (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  mffd_pkg::item_t wr_item,
  input  logic            pop,
  output mffd_pkg::item_t rd_item,
  output logic            full,
  output logic            empty
);
  import mffd_pkg::*;

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  item_t             entries [QUEUE_DEPTH];
  logic [PTR_W-1:0]  wr_ptr;
  logic [PTR_W-1:0]  rd_ptr;
  logic [CNT_W-1:0]  count;

  assign full    = (count == CNT_W'(QUEUE_DEPTH));
  assign empty   = (count == '0);
  assign rd_item = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + PTR_W'(1);
      end
      if (push && !pop) begin
        count <= count + CNT_W'(1);
      end else if (pop && !push) begin
        count <= count - CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= wr_item;
    end
  end

endmodule

// ===== sv/mffd_fold.sv =====
// Divider by 2^b-1 that folds b-bit digits, one fold per cycle, then halves.
module mffd_fold #(
  parameter int FRAC_BITS = mffd_pkg::FRAC_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  input  logic                 wide,
  input  logic [FRAC_BITS+22:0] num,
  output logic                 busy,
  output logic [FRAC_BITS+6:0] quot
);
  import mffd_pkg::*;

  localparam int NW = FRAC_BITS + 23;
  localparam int QW = FRAC_BITS + 7;

  logic [NW-1:0] rem;
  logic [NW-1:0] acc;
  logic          wide_r;
  logic [NW-1:0] hi;
  logic [NW-1:0] lo;
  logic [NW-1:0] den;
  logic [NW-1:0] sum;
  logic          last;

  always_comb begin
    if (wide_r) begin
      hi  = rem >> WIDE_BITS;
      lo  = NW'(rem[WIDE_BITS-1:0]);
      den = NW'(DEN_WIDE);
    end else begin
      hi  = rem >> NARROW_BITS;
      lo  = NW'(rem[NARROW_BITS-1:0]);
      den = NW'(DEN_NARROW);
    end
    last = (hi == '0);
    sum  = acc + NW'(rem == den);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
    end else if (start) begin
      busy <= 1'b1;
    end else if (busy && last) begin
      busy <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem    <= num;
      acc    <= '0;
      wide_r <= wide;
    end else if (busy && !last) begin
      acc <= acc + hi;
      rem <= hi + lo;
    end
    if (busy && last) begin
      quot <= sum[QW:1];
    end
  end

endmodule

// ===== sv/mffd_back.sv =====
// Back end: scales the codes, updates the velocity average and holds the result.
module mffd_back #(
  parameter int NUM_MOTORS = mffd_pkg::NUM_MOTORS_DEF,
  parameter int FRAC_BITS  = mffd_pkg::FRAC_BITS_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        queue_empty,
  input  mffd_pkg::item_t             queue_item,
  output logic                        pop,
  input  logic [16:0]                 alpha,
  output logic                        result_valid,
  input  logic                        result_stall,
  output logic [1:0]                  slot,
  output logic [3:0]                  error_code,
  output logic signed [FRAC_BITS+4:0] position,
  output logic signed [FRAC_BITS+5:0] velocity,
  output logic signed [FRAC_BITS+5:0] filtered_velocity,
  output logic signed [FRAC_BITS+5:0] torque,
  output logic signed [7:0]           driver_temp,
  output logic signed [7:0]           rotor_temp
);
  import mffd_pkg::*;

  localparam int POS_W  = FRAC_BITS + 5;
  localparam int VEL_W  = FRAC_BITS + 6;
  localparam int NW     = FRAC_BITS + 23;
  localparam int QW     = FRAC_BITS + 7;
  localparam int RW     = FRAC_BITS + 8;
  localparam int PW     = VEL_W + 19;
  localparam int SLOT_W = (NUM_MOTORS > 1) ? $clog2(NUM_MOTORS) : 1;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_CONV = 2'd1;
  localparam logic [1:0] S_MUL  = 2'd2;
  localparam logic [1:0] S_UPD  = 2'd3;

  logic [1:0]              state;
  item_t                   item_r;
  logic                    start;
  logic [NW-1:0]           pos_num;
  logic [NW-1:0]           vel_num;
  logic [NW-1:0]           trq_num;
  logic [6:0]              vel_span_in;
  logic [6:0]              trq_span_in;
  logic [6:0]              vel_span_r;
  logic [6:0]              trq_span_r;
  logic                    pos_busy;
  logic                    vel_busy;
  logic                    trq_busy;
  logic [QW-1:0]           pos_q;
  logic [QW-1:0]           vel_q;
  logic [QW-1:0]           trq_q;
  logic [RW-1:0]           pos_ofs;
  logic [RW-1:0]           vel_ofs;
  logic [RW-1:0]           trq_ofs;
  logic signed [RW-1:0]    pos_full;
  logic signed [RW-1:0]    vel_full;
  logic signed [RW-1:0]    trq_full;
  logic signed [POS_W-1:0] pos_r;
  logic signed [VEL_W-1:0] vel_r;
  logic signed [VEL_W-1:0] trq_r;
  logic signed [VEL_W-1:0] filt_mem [NUM_MOTORS];
  logic [SLOT_W-1:0]       idx;
  logic signed [VEL_W-1:0] filt_cur;
  logic signed [VEL_W-1:0] filt_r;
  logic signed [VEL_W:0]   diff;
  logic signed [PW-1:0]    prod_r;
  logic signed [PW-1:0]    rnd;
  logic signed [VEL_W-1:0] filt_new;
  logic                    out_free;
  logic                    finish;

  assign start    = (state == S_IDLE) && !queue_empty;
  assign pop      = start;
  assign out_free = !result_valid || !result_stall;
  assign finish   = (state == S_UPD) && out_free;
  assign idx      = item_r.slot[SLOT_W-1:0];
  assign filt_cur = filt_mem[idx];

  always_comb begin
    vel_span_in = queue_item.model ? VEL_SPAN2_M1 : VEL_SPAN2_M0;
    trq_span_in = queue_item.model ? TRQ_SPAN2_M1 : TRQ_SPAN2_M0;
    pos_num = ((NW'(queue_item.pcode) * NW'(POS_SPAN2)) << FRAC_BITS) + NW'(DEN_WIDE);
    vel_num = ((NW'(queue_item.vcode) * NW'(vel_span_in)) << FRAC_BITS) + NW'(DEN_NARROW);
    trq_num = ((NW'(queue_item.tcode) * NW'(trq_span_in)) << FRAC_BITS) + NW'(DEN_NARROW);

    // The lower end of each range is minus half its span.
    pos_ofs  = RW'(POS_SPAN2) << (FRAC_BITS - 2);
    vel_ofs  = RW'(vel_span_r) << (FRAC_BITS - 2);
    trq_ofs  = RW'(trq_span_r) << (FRAC_BITS - 2);
    pos_full = $signed({1'b0, pos_q}) - $signed(pos_ofs);
    vel_full = $signed({1'b0, vel_q}) - $signed(vel_ofs);
    trq_full = $signed({1'b0, trq_q}) - $signed(trq_ofs);

    diff     = {vel_r[VEL_W-1], vel_r} - {filt_cur[VEL_W-1], filt_cur};
    rnd      = (prod_r + PW'(ALPHA_HALF)) >>> ALPHA_FRAC;
    filt_new = filt_r + rnd[VEL_W-1:0];
  end

  mffd_fold #(.FRAC_BITS(FRAC_BITS)) u_pos_fold (
    .clk(clk), .rst(rst), .start(start), .wide(1'b1),
    .num(pos_num), .busy(pos_busy), .quot(pos_q)
  );

  mffd_fold #(.FRAC_BITS(FRAC_BITS)) u_vel_fold (
    .clk(clk), .rst(rst), .start(start), .wide(1'b0),
    .num(vel_num), .busy(vel_busy), .quot(vel_q)
  );

  mffd_fold #(.FRAC_BITS(FRAC_BITS)) u_trq_fold (
    .clk(clk), .rst(rst), .start(start), .wide(1'b0),
    .num(trq_num), .busy(trq_busy), .quot(trq_q)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (start) begin
            state <= S_CONV;
          end
        end
        S_CONV: begin
          if (!pos_busy && !vel_busy && !trq_busy) begin
            state <= S_MUL;
          end
        end
        S_MUL: begin
          state <= S_UPD;
        end
        S_UPD: begin
          if (out_free) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      item_r     <= queue_item;
      vel_span_r <= vel_span_in;
      trq_span_r <= trq_span_in;
    end
    if ((state == S_CONV) && !pos_busy && !vel_busy && !trq_busy) begin
      pos_r <= pos_full[POS_W-1:0];
      vel_r <= vel_full[VEL_W-1:0];
      trq_r <= trq_full[VEL_W-1:0];
    end
    if (state == S_MUL) begin
      prod_r <= $signed({1'b0, alpha}) * diff;
      filt_r <= filt_cur;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_MOTORS; i++) begin
        filt_mem[i] <= '0;
      end
    end else if (finish) begin
      filt_mem[idx] <= filt_new;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (finish) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (finish) begin
      slot              <= item_r.slot[1:0];
      error_code        <= item_r.error_code;
      position          <= pos_r;
      velocity          <= vel_r;
      filtered_velocity <= filt_new;
      torque            <= trq_r;
      driver_temp       <= $signed(item_r.driver_temp);
      rotor_temp        <= $signed(item_r.rotor_temp);
    end
  end

endmodule

// ===== sv/motor_feedback_frame_decoder.sv =====
// Top level of the motor feedback frame decoder with its register port.
// Each frame transfer whose identifier lies in 1 to NUM_MOTORS yields one
// result transfer; frames with any other identifier are dropped by the front
// end in the cycle they are taken. Position, velocity and torque are scaled
// to signed fixed point with FRAC_BITS fraction bits, rounded to nearest, and
// each slot keeps a moving average of velocity that starts at zero after reset.
// An accepted frame passes through the back end in order: it is taken from
// the queue, the three constant dividers fold the scaled code one 12- or
// 16-bit digit per cycle in parallel, then finish and have their quotients
// collected, the smoothing multiply follows, and then the average is updated
// and the output register loaded; a stalled result holds in the output
// register. A two-entry queue lets the front end keep taking frames while
// the back end works and while a finished result waits on the output.
module motor_feedback_frame_decoder #(
  parameter int NUM_MOTORS = mffd_pkg::NUM_MOTORS_DEF,
  parameter int FRAC_BITS  = mffd_pkg::FRAC_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [mffd_pkg::CFG_ADDR_W-1:0]   paddr,
  input  logic [31:0]                       pwdata,
  output logic [31:0]                       prdata,
  output logic                              pready,
  input  logic                              frame_valid,
  output logic                              frame_stall,
  input  logic [10:0]                       frame_id,
  input  logic [7:0]                        byte0,
  input  logic [7:0]                        byte1,
  input  logic [7:0]                        byte2,
  input  logic [7:0]                        byte3,
  input  logic [7:0]                        byte4,
  input  logic [7:0]                        byte5,
  input  logic [7:0]                        byte6,
  input  logic [7:0]                        byte7,
  output logic                              result_valid,
  input  logic                              result_stall,
  output logic [1:0]                        slot,
  output logic [3:0]                        error_code,
  output logic signed [FRAC_BITS+4:0]       position,
  output logic signed [FRAC_BITS+5:0]       velocity,
  output logic signed [FRAC_BITS+5:0]       filtered_velocity,
  output logic signed [FRAC_BITS+5:0]       torque,
  output logic signed [7:0]                 driver_temp,
  output logic signed [7:0]                 rotor_temp
);
  import mffd_pkg::*;

  logic [3:0]  model_select_mask;
  logic [16:0] ema_alpha;
  logic [16:0] alpha_sat;
  logic        reg_write;
  logic        reg_sel;
  logic        push;
  logic        pop;
  logic        queue_full;
  logic        queue_empty;
  item_t       wr_item;
  item_t       rd_item;

  assign pready    = 1'b1;
  assign reg_sel   = paddr[CFG_ADDR_W-1];
  assign reg_write = psel && penable && pwrite && pready;
  assign alpha_sat = ema_alpha[16] ? ALPHA_ONE : ema_alpha;

  always_ff @(posedge clk) begin
    if (rst) begin
      model_select_mask <= MODEL_MASK_RESET;
      ema_alpha         <= EMA_ALPHA_RESET;
    end else if (reg_write) begin
      unique case (reg_sel)
        REG_MODEL_MASK: model_select_mask <= pwdata[3:0];
        REG_EMA_ALPHA:  ema_alpha         <= pwdata[16:0];
        default:        model_select_mask <= model_select_mask;
      endcase
    end
  end

  always_comb begin
    unique case (reg_sel)
      REG_MODEL_MASK: prdata = {28'd0, model_select_mask};
      REG_EMA_ALPHA:  prdata = {15'd0, ema_alpha};
      default:        prdata = '0;
    endcase
  end

  mffd_front #(.NUM_MOTORS(NUM_MOTORS)) u_front (
    .rst(rst),
    .frame_valid(frame_valid),
    .frame_stall(frame_stall),
    .frame_id(frame_id),
    .byte0(byte0),
    .byte1(byte1),
    .byte2(byte2),
    .byte3(byte3),
    .byte4(byte4),
    .byte5(byte5),
    .byte6(byte6),
    .byte7(byte7),
    .model_select_mask(model_select_mask),
    .queue_full(queue_full),
    .push(push),
    .item(wr_item)
  );

  mffd_queue u_queue (
    .clk(clk),
    .rst(rst),
    .push(push),
    .wr_item(wr_item),
    .pop(pop),
    .rd_item(rd_item),
    .full(queue_full),
    .empty(queue_empty)
  );

  mffd_back #(.NUM_MOTORS(NUM_MOTORS), .FRAC_BITS(FRAC_BITS)) u_back (
    .clk(clk),
    .rst(rst),
    .queue_empty(queue_empty),
    .queue_item(rd_item),
    .pop(pop),
    .alpha(alpha_sat),
    .result_valid(result_valid),
    .result_stall(result_stall),
    .slot(slot),
    .error_code(error_code),
    .position(position),
    .velocity(velocity),
    .filtered_velocity(filtered_velocity),
    .torque(torque),
    .driver_temp(driver_temp),
    .rotor_temp(rotor_temp)
  );

endmodule

// ===== verif/tb.sv =====
// Self-checking testbench for the motor feedback frame decoder.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import mffd_pkg::*;

  typedef struct packed {
    logic [1:0]  slot;
    logic [3:0]  err;
    logic [20:0] pos;
    logic [21:0] vel;
    logic [21:0] filt;
    logic [21:0] trq;
    logic [7:0]  dtemp;
    logic [7:0]  rtemp;
  } feedback_t;

  typedef struct packed {
    logic [10:0] id;
    logic [63:0] data;
    bit          typed;
    feedback_t   want;
  } directed_row_t;

  logic clk = 1'b0;
  logic rst;
  logic psel, penable, pwrite;
  logic [CFG_ADDR_W-1:0] paddr;
  logic [31:0] pwdata, prdata;
  logic pready;
  logic frame_valid, frame_stall;
  logic [10:0] frame_id;
  logic [7:0] byte0, byte1, byte2, byte3, byte4, byte5, byte6, byte7;
  logic result_valid, result_stall;
  logic [1:0] slot;
  logic [3:0] error_code;
  logic signed [20:0] position;
  logic signed [21:0] velocity, filtered_velocity, torque;
  logic signed [7:0] driver_temp, rotor_temp;

  motor_feedback_frame_decoder dut (
    .clk(clk), .rst(rst),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready),
    .frame_valid(frame_valid), .frame_stall(frame_stall), .frame_id(frame_id),
    .byte0(byte0), .byte1(byte1), .byte2(byte2), .byte3(byte3),
    .byte4(byte4), .byte5(byte5), .byte6(byte6), .byte7(byte7),
    .result_valid(result_valid), .result_stall(result_stall),
    .slot(slot), .error_code(error_code), .position(position),
    .velocity(velocity), .filtered_velocity(filtered_velocity), .torque(torque),
    .driver_temp(driver_temp), .rotor_temp(rotor_temp)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  feedback_t pending_feedback [$];
  longint    smoothed_vel [4];
  logic [3:0]  model_mask;
  logic [16:0] alpha_q16;
  int failures = 0;
  bit gaps_on = 1'b1;
  bit stalls_on = 1'b1;

  directed_row_t directed_rows [19] = '{
    '{11'd1, 64'h0, 1'b1, '{2'd0, 4'd0, -21'sd819200, -22'sd655360, -22'sd655360,
                            -22'sd1835008, 8'h00, 8'h00}},
    '{11'd2, {8{8'hFF}}, 1'b1, '{2'd1, 4'd15, 21'sd819200, 22'sd655360, 22'sd655360,
                                 22'sd1835008, 8'hFF, 8'hFF}},
    '{11'd3, 64'h0, 1'b1, '{2'd2, 4'd0, -21'sd819200, -22'sd1966080, -22'sd1966080,
                            -22'sd655360, 8'h00, 8'h00}},
    '{11'd4, {8{8'hFF}}, 1'b1, '{2'd3, 4'd15, 21'sd819200, 22'sd1966080, 22'sd1966080,
                                 22'sd655360, 8'hFF, 8'hFF}},
    '{11'd1, 64'hA500_0000_0000_807F, 1'b1,
      '{2'd0, 4'd10, -21'sd819200, -22'sd655360, -22'sd655360, -22'sd1835008,
        8'h80, 8'h7F}},
    '{11'd4, 64'h5A00_0000_0000_7F80, 1'b1,
      '{2'd3, 4'd5, -21'sd819200, -22'sd1966080, -22'sd1966080, -22'sd655360,
        8'h7F, 8'h80}},
    '{11'd0, {8{8'hFF}}, 1'b0, '0},
    '{11'd5, 64'h1234_5678_9ABC_DEF0, 1'b0, '0},
    '{11'd2047, {8{8'hFF}}, 1'b0, '0},
    '{11'h400, 64'h0, 1'b0, '0},
    '{11'd1023, 64'hFFFF_0000_FFFF_0000, 1'b0, '0},
    '{11'd1, 64'h0080_0080_0800_1122, 1'b0, '0},
    '{11'd2, 64'h307F_FF7F_F7FF_0000, 1'b0, '0},
    '{11'd3, 64'hF080_0080_0800_FE01, 1'b0, '0},
    '{11'd4, 64'h107F_FF7F_F7FF_649C, 1'b0, '0},
    '{11'd1, 64'h5AAA_55AA_55AA_55AA, 1'b0, '0},
    '{11'd3, 64'hC355_AA55_AA55_AA55, 1'b0, '0},
    '{11'd2, 64'h0F01_0000_1F01_0000, 1'b0, '0},
    '{11'd4, 64'hE0FF_FEFF_EFFE_0000, 1'b0, '0}
  };

  function automatic longint floor_quot(longint n, longint d);
    if (n >= 0) return n / d;
    return -((-n + d - 1) / d);
  endfunction

  // Maps a code onto [lo, lo + span] with lo2 = 2*lo and span2 = 2*span,
  // rounding to nearest with ties toward plus infinity.
  function automatic longint scale_code(longint code, int bits, longint lo2, longint span2);
    longint den, one, num;
    den = (longint'(1) << bits) - 1;
    one = longint'(1) << FRAC_BITS_DEF;
    num = code * span2 * one + lo2 * one * den;
    return floor_quot(2 * num + 2 * den, 4 * den);
  endfunction

  function automatic bit decode_feedback(logic [10:0] id, logic [63:0] data,
                                         output feedback_t res);
    int s;
    bit model;
    longint pcode, vcode, tcode, pos, vel, trq, alpha, filt;
    res = '0;
    if (id < 1 || id > NUM_MOTORS_DEF) return 1'b0;
    s = id - 1;
    model = model_mask[s];
    pcode = data[55:40];
    vcode = data[39:28];
    tcode = data[27:16];
    pos = scale_code(pcode, 16, -25, 50);
    if (model) begin
      vel = scale_code(vcode, 12, -20, 40);
      trq = scale_code(tcode, 12, -56, 112);
    end else begin
      vel = scale_code(vcode, 12, -60, 120);
      trq = scale_code(tcode, 12, -20, 40);
    end
    alpha = (alpha_q16 > 17'd65536) ? 65536 : longint'(alpha_q16);
    filt = smoothed_vel[s];
    filt += floor_quot(alpha * (vel - filt) + 32768, 65536);
    smoothed_vel[s] = filt;
    res.slot = s[1:0];
    res.err = data[63:60];
    res.pos = pos[20:0];
    res.vel = vel[21:0];
    res.filt = filt[21:0];
    res.trq = trq[21:0];
    res.dtemp = data[15:8];
    res.rtemp = data[7:0];
    return 1'b1;
  endfunction

  task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      failures++;
      if (failures <= 10)
        $display("mismatch on %s: expected %h, got %h", name, want, got);
    end
  endtask

  always @(posedge clk) begin
    feedback_t got, want;
    if (!rst && result_valid && !result_stall) begin
      got = '{slot, error_code, position, velocity, filtered_velocity, torque,
              driver_temp, rotor_temp};
      if (pending_feedback.size() == 0) begin
        failures++;
        if (failures <= 10) $display("result transfer with no frame pending: %h", got);
      end else begin
        want = pending_feedback.pop_front();
        check_field("slot", want.slot, got.slot);
        check_field("error_code", want.err, got.err);
        check_field("position", want.pos, got.pos);
        check_field("velocity", want.vel, got.vel);
        check_field("filtered_velocity", want.filt, got.filt);
        check_field("torque", want.trq, got.trq);
        check_field("driver_temp", want.dtemp, got.dtemp);
        check_field("rotor_temp", want.rtemp, got.rtemp);
      end
    end
  end

  initial begin
    int level, len;
    result_stall <= 1'b0;
    forever begin
      level = stalls_on && ($urandom_range(0, 2) == 0);
      len = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 3);
      repeat (len) begin
        @(negedge clk);
        result_stall <= level[0];
      end
    end
  end

  task automatic write_reg(logic idx, logic [31:0] value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= value;
    @(negedge clk);
    penable <= 1'b1;
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(negedge clk);
    if (idx == REG_MODEL_MASK) model_mask = value[3:0];
    else alpha_q16 = value[16:0];
  endtask

  task automatic wait_idle();
    frame_valid <= 1'b0;
    while (pending_feedback.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic pace_sender();
    int r, gap;
    r = $urandom_range(0, 99);
    gap = !gaps_on ? 0 : (r < 60) ? 0 : (r < 92) ? $urandom_range(1, 3)
                                                  : $urandom_range(8, 40);
    if (gap > 0) begin
      frame_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
  endtask

  task automatic send_frame(logic [10:0] id, logic [63:0] data, bit typed, feedback_t want);
    feedback_t res;
    pace_sender();
    frame_valid <= 1'b1;
    frame_id <= id;
    {byte0, byte1, byte2, byte3, byte4, byte5, byte6, byte7} <= data;
    do @(posedge clk); while (frame_stall);
    if (decode_feedback(id, data, res)) pending_feedback.push_back(typed ? want : res);
    @(negedge clk);
  endtask

  function automatic logic [7:0] rand_byte();
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) return 8'h00;
    if (r == 1) return 8'hFF;
    return 8'($urandom_range(0, 255));
  endfunction

  task automatic run_random(int count);
    int sent, r;
    logic [10:0] id;
    logic [63:0] data;
    sent = 0;
    while (sent < count) begin
      r = $urandom_range(0, 99);
      id = (r < 85) ? 11'($urandom_range(1, 4)) : (r < 88) ? 11'd0 :
           (r < 90) ? 11'd2047 : 11'($urandom_range(5, 2047));
      for (int i = 0; i < 8; i++) data[8*i +: 8] = rand_byte();
      send_frame(id, data, 1'b0, '0);
      if (id >= 1 && id <= NUM_MOTORS_DEF) sent++;
      if (sent == count / 2 && id >= 1 && id <= NUM_MOTORS_DEF) wait_idle();
    end
    wait_idle();
  endtask

  task automatic run_phase(logic [3:0] mask, logic [16:0] alpha, int count,
                           bit gaps, bit stalls);
    write_reg(REG_MODEL_MASK, 32'(mask));
    write_reg(REG_EMA_ALPHA, 32'(alpha));
    gaps_on = gaps;
    stalls_on = stalls;
    run_random(count);
  endtask

  initial begin
    rst <= 1'b1;
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= '0;
    pwdata <= '0;
    frame_valid <= 1'b0;
    frame_id <= '0;
    {byte0, byte1, byte2, byte3, byte4, byte5, byte6, byte7} <= '0;
    model_mask = MODEL_MASK_RESET;
    alpha_q16 = EMA_ALPHA_RESET;
    foreach (smoothed_vel[i]) smoothed_vel[i] = 0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    run_random(150);

    write_reg(REG_MODEL_MASK, 32'd3);
    write_reg(REG_EMA_ALPHA, 32'(ALPHA_ONE));
    foreach (directed_rows[i])
      send_frame(directed_rows[i].id, directed_rows[i].data, directed_rows[i].typed,
                 directed_rows[i].want);
    wait_idle();

    run_phase(4'h0, 17'd0, 150, 1'b1, 1'b1);
    run_phase(4'hF, 17'd65536, 150, 1'b0, 1'b0);
    run_phase(4'h5, 17'd1, 150, 1'b1, 1'b1);
    run_phase(4'hA, 17'h1FFFF, 150, 1'b1, 1'b1);
    run_phase(4'($urandom_range(0, 15)), 17'($urandom_range(0, 131071)), 150, 1'b1, 1'b0);
    run_phase(4'($urandom_range(0, 15)), 17'($urandom_range(0, 65536)), 100, 1'b0, 1'b1);

    if (failures == 0 && pending_feedback.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("TEST FAILED");
    $finish;
  end

endmodule

// ===== filelist.f =====
sv/mffd_pkg.sv
sv/mffd_front.sv
sv/mffd_queue.sv
sv/mffd_fold.sv
sv/mffd_back.sv
sv/motor_feedback_frame_decoder.sv
verif/tb.sv
